>>> design/pol_pkg.sv
// Shared types and constants for the positional ordered list.
// No dependencies; used by every module in this folder.
package pol_pkg;

   localparam int CAPACITY_DEF = 64;

   // Item field widths
   localparam int ACT_W    = 2;
   localparam int POS_W    = 7;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Index/count width broadcast along the chain, wide enough for any capacity up to 4095
   localparam int IDX_W = 12;

   // Reduction tree: fan-in per node and number of registered levels
   localparam int FAN         = 8;
   localparam int TREE_LEVELS = 4;

   // Leaf word: {hit, read data}
   localparam int WORD_W = VAL_W + 1;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_GET    = 2'd2;
   localparam logic [ACT_W-1:0] ACT_FIND   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

   // Command broadcast to every cell
   typedef struct packed {
      logic             load;
      logic             ins_en;
      logic             rem_en;
      logic             get_en;
      logic             find_en;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] cnt;
      logic [VAL_W-1:0] key;
   } pol_cmd_type;

endpackage

>>> design/positional_ordered_list_core.sv
// Positional ordered list of up to CAPACITY signed 32-bit values. Each cell of a chain holds one
// entry; insert and remove shift the affected cells by one place at the accept edge, and the count
// and status are settled there too. Get and find gather each cell's contribution through a
// four-level registered OR tree (fan-in 8). A result passes from the registered cell contributions
// through the four tree levels into the output register; a held-off result stalls it before that
// last load. The next item is taken only once the previous result has been loaded into the output
// register. A result waiting in the output register does not block the next item from being
// accepted.
// Depends on pol_pkg, pol_cell and pol_or_stage.
module positional_ordered_list_core import pol_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ACT_W-1:0]           req_action,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [VAL_W-1:0]    req_item_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VAL_W-1:0]    rsp_read_value,
   output logic                       rsp_found,
   output logic [COUNT_W-1:0]         rsp_entry_count
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int L1 = (CAPACITY + FAN - 1) / FAN;
   localparam int L2 = (L1 + FAN - 1) / FAN;
   localparam int L3 = (L2 + FAN - 1) / FAN;
   localparam int WAIT_W = $clog2(TREE_LEVELS + 1);
   localparam logic [IDX_W-1:0] CAP_X = IDX_W'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [WAIT_W-1:0]    wait_ff, wait_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [STATUS_W-1:0]  pend_status_ff, pend_status_in;
   logic [COUNT_W-1:0]   pend_count_ff, pend_count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 accept;
   logic                 finish;
   logic [IDX_W-1:0]     cnt_x, pos_x, cnt_next_x;
   logic                 pos_bad;
   pol_cmd_type          cmd;

   logic [CAPACITY-1:0][VAL_W-1:0]  cell_val;
   logic [CAPACITY-1:0][WORD_W-1:0] leaf;
   logic [L1-1:0][WORD_W-1:0]       lvl1;
   logic [L2-1:0][WORD_W-1:0]       lvl2;
   logic [L3-1:0][WORD_W-1:0]       lvl3;
   logic [(L3+FAN-1)/FAN-1:0][WORD_W-1:0] lvl4;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;

   // Command decode against the count before this item
   always_comb begin
      cnt_x          = IDX_W'(count_ff);
      pos_x          = IDX_W'(req_position);
      cnt_next_x     = cnt_x;
      pend_status_in = STATUS_DONE;
      cmd            = '0;
      cmd.load       = accept;
      cmd.cnt        = cnt_x;
      cmd.key        = req_item_value;
      cmd.idx        = pos_x - IDX_W'(1);
      pos_bad        = (pos_x == '0) || (pos_x > cnt_x);
      case (req_action)
         ACT_INSERT: begin
            if (cnt_x == '0) begin
               // empty list takes the value at the head whatever the position
               cmd.ins_en = 1'b1;
               cmd.idx    = '0;
               cnt_next_x = IDX_W'(1);
            end else if (cnt_x >= CAP_X) begin
               pend_status_in = STATUS_FULL;
            end else if (pos_x == '0 || pos_x > cnt_x + IDX_W'(1)) begin
               pend_status_in = STATUS_BADPOS;
            end else begin
               cmd.ins_en = 1'b1;
               cnt_next_x = cnt_x + IDX_W'(1);
            end
         end
         ACT_REMOVE: begin
            if (pos_bad) begin
               pend_status_in = STATUS_BADPOS;
            end else begin
               cmd.rem_en = 1'b1;
               cnt_next_x = cnt_x - IDX_W'(1);
            end
         end
         ACT_GET: begin
            if (pos_bad) begin
               pend_status_in = STATUS_BADPOS;
            end else begin
               cmd.get_en = 1'b1;
            end
         end
         default: begin
            cmd.find_en = 1'b1;
         end
      endcase
      pend_count_in = COUNT_W'(cnt_next_x);
      count_in      = accept ? CW'(cnt_next_x) : count_ff;
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         pol_cell #(
            .INDEX(gi)
         ) u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .left_val  ((gi == 0) ? cell_val[gi] : cell_val[(gi == 0) ? 0 : gi - 1]),
            .right_val ((gi == CAPACITY - 1) ? cell_val[gi]
                                             : cell_val[(gi == CAPACITY - 1) ? gi : gi + 1]),
            .cell_val  (cell_val[gi]),
            .leaf_word (leaf[gi])
         );
      end
   endgenerate

   pol_or_stage #(.N_IN(CAPACITY)) u_lvl1 (.clock(clock), .din(leaf), .dout(lvl1));
   pol_or_stage #(.N_IN(L1))       u_lvl2 (.clock(clock), .din(lvl1), .dout(lvl2));
   pol_or_stage #(.N_IN(L2))       u_lvl3 (.clock(clock), .din(lvl2), .dout(lvl3));
   pol_or_stage #(.N_IN(L3))       u_lvl4 (.clock(clock), .din(lvl3), .dout(lvl4));

   // Tree output is final once the last level has been loaded
   assign finish = (state_ff == ST_BUSY) && (wait_ff == WAIT_W'(TREE_LEVELS))
                   && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_BUSY;
               wait_in  = '0;
            end
         end
         ST_BUSY: begin
            if (wait_ff != WAIT_W'(TREE_LEVELS)) begin
               wait_in = wait_ff + WAIT_W'(1);
            end
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_value_in  = lvl4[0][VAL_W-1:0];
         rsp_found_in  = lvl4[0][WORD_W-1];
         rsp_count_in  = pend_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff <= pend_status_in;
         pend_count_ff  <= pend_count_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

>>> design/pol_cell.sv
// One list entry: holds a value, shifts to/from its neighbours, and registers
// its local find/get contribution. Depends on pol_pkg.
module pol_cell import pol_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  pol_cmd_type       cmd,
   input  logic [VAL_W-1:0]  left_val,
   input  logic [VAL_W-1:0]  right_val,
   output logic [VAL_W-1:0]  cell_val,
   output logic [WORD_W-1:0] leaf_word
);

   localparam logic [IDX_W-1:0] ME      = IDX_W'(INDEX);
   localparam logic [IDX_W-1:0] ME_NEXT = IDX_W'(INDEX + 1);

   logic [VAL_W-1:0]  val_ff, val_in;
   logic [WORD_W-1:0] leaf_ff, leaf_in;
   logic              hit;
   logic [VAL_W-1:0]  rd;

   always_comb begin
      val_in = val_ff;
      if (cmd.load) begin
         if (cmd.ins_en) begin
            if (ME == cmd.idx) begin
               val_in = cmd.key;
            end else if (ME > cmd.idx && ME <= cmd.cnt) begin
               val_in = left_val;
            end
         end else if (cmd.rem_en) begin
            if (ME >= cmd.idx && ME_NEXT < cmd.cnt) begin
               val_in = right_val;
            end
         end
      end
   end

   // Contribution uses the contents before this item's update
   always_comb begin
      hit     = cmd.find_en && (ME < cmd.cnt) && (val_ff == cmd.key);
      rd      = (cmd.get_en && ME == cmd.idx) ? val_ff : '0;
      leaf_in = cmd.load ? {hit, rd} : leaf_ff;
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      leaf_ff <= leaf_in;
   end

   assign cell_val  = val_ff;
   assign leaf_word = leaf_ff;

endmodule

>>> design/pol_or_stage.sv
// One registered level of the OR reduction tree over cell contributions.
// Depends on pol_pkg.
module pol_or_stage import pol_pkg::*; #(
   parameter int N_IN = 64
) (
   input  logic                               clock,
   input  logic [N_IN-1:0][WORD_W-1:0]        din,
   output logic [(N_IN+FAN-1)/FAN-1:0][WORD_W-1:0] dout
);

   localparam int N_OUT = (N_IN + FAN - 1) / FAN;

   logic [N_OUT-1:0][WORD_W-1:0] node_in;

   always_comb begin
      for (int j = 0; j < N_OUT; j++) begin
         node_in[j] = '0;
         for (int k = 0; k < FAN; k++) begin
            if (j * FAN + k < N_IN) begin
               node_in[j] = node_in[j] | din[j * FAN + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      dout <= node_in;
   end

endmodule
